/* hdl/tao_pkg.sv */
// ----------------------------------------------------------------------------
// tao_pkg
// Shared types and constants of the table-based two-argument arctangent unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tao_pkg;

  localparam int TableEntries = 1025;
  localparam int IdxW         = 11;
  localparam int ValW         = 16;
  localparam int AngW         = 17;
  localparam int DataW        = 32;
  localparam int RatioShift   = 10;
  localparam int DivSteps     = 11;                 // quotient bits resolved
  localparam int RemW         = DataW + DivSteps;   // partial remainder width
  localparam int PipeLat      = DivSteps + 4;       // start to done, cycles

  localparam logic [DataW-1:0] ReduceMask  = 32'h7fe0_0000;
  localparam logic [AngW-1:0]  QuarterTurn = 17'd1024;
  localparam logic [AngW-1:0]  HalfTurn    = 17'd2048;

  typedef enum logic [2:0] {
    PATH_ZERO = 3'd0,
    PATH_ZRED = 3'd1,
    PATH_ZSHF = 3'd2,
    PATH_XRED = 3'd3,
    PATH_XSHF = 3'd4,
    PATH_LOAD = 3'd5
  } path_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DIV0  = 2'd1,
    ERR_OVF   = 2'd2,
    ERR_RANGE = 2'd3
  } err_e;

  typedef struct packed {
    logic                   valid;
    logic                   load;
    path_e                  path;
    err_e                   err;
    logic                   neg_z;
    logic                   neg_x;
    logic                   z_less;
    logic [IdxW-1:0]        entry_idx;
    logic signed [ValW-1:0] entry_val;
  } meta_t;

endpackage

`default_nettype wire

/* hdl/tao_div.sv */
// ----------------------------------------------------------------------------
// tao_div
// Pipelined restoring divider: one quotient bit per stage, quotient range
// limited to DivSteps bits; larger quotients are flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module tao_div (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  tao_pkg::meta_t                  meta_i,
  input  wire  [tao_pkg::DataW-1:0]       num_i,
  input  wire  [tao_pkg::DataW-1:0]       den_i,
  output tao_pkg::meta_t                  meta_o,
  output logic [tao_pkg::DivSteps-1:0]    quo_o,
  output logic                            big_o,
  output logic                            neg_o
);

  localparam int N = tao_pkg::DivSteps;

  tao_pkg::meta_t              meta_q [N+1];
  logic [tao_pkg::RemW-1:0]    rem_q  [N+1];
  logic [tao_pkg::DataW-1:0]   dmag_q [N+1];
  logic [N-1:0]                quo_q  [N+1];
  logic                        big_q  [N+1];
  logic                        neg_q  [N+1];

  logic [tao_pkg::DataW-1:0] nmag_d, dmag_d;
  logic [tao_pkg::RemW-1:0]  dlim_d;

  // Magnitudes; the most negative value maps to 2^31, which still fits.
  always_comb begin
    nmag_d = num_i[tao_pkg::DataW-1] ? (~num_i + 32'd1) : num_i;
    dmag_d = den_i[tao_pkg::DataW-1] ? (~den_i + 32'd1) : den_i;
    dlim_d = {dmag_d, {N{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q[0] <= '0;
    end else begin
      meta_q[0] <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= {{N{1'b0}}, nmag_d};
    dmag_q[0] <= dmag_d;
    quo_q[0]  <= '0;
    big_q[0]  <= ({{N{1'b0}}, nmag_d} >= dlim_d);
    neg_q[0]  <= num_i[tao_pkg::DataW-1] ^ den_i[tao_pkg::DataW-1];
  end

  for (genvar j = 1; j <= N; j++) begin : g_stage
    localparam int K = N - j;
    logic [tao_pkg::RemW-1:0] dsh;
    logic                     fit;

    always_comb begin
      dsh = {{N{1'b0}}, dmag_q[j-1]} << K;
      fit = (rem_q[j-1] >= dsh);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[j] <= '0;
      end else begin
        meta_q[j] <= meta_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= fit ? (rem_q[j-1] - dsh) : rem_q[j-1];
      quo_q[j]  <= {quo_q[j-1][N-2:0], fit};
      dmag_q[j] <= dmag_q[j-1];
      big_q[j]  <= big_q[j-1];
      neg_q[j]  <= neg_q[j-1];
    end
  end

  assign meta_o = meta_q[N];
  assign quo_o  = quo_q[N];
  assign big_o  = big_q[N];
  assign neg_o  = neg_q[N];

endmodule

`default_nettype wire

/* hdl/tao_tab.sv */
// ----------------------------------------------------------------------------
// tao_tab
// Angle table memory, range check of the quotient, and octant fold.
// ----------------------------------------------------------------------------
`default_nettype none

module tao_tab #(
  parameter int TABLE_ENTRIES = tao_pkg::TableEntries
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  tao_pkg::meta_t                     meta_i,
  input  wire  [tao_pkg::DivSteps-1:0]       quo_i,
  input  wire                                big_i,
  input  wire                                neg_i,
  output logic                               done_o,
  output logic signed [tao_pkg::AngW-1:0]    angle_o,
  output logic [tao_pkg::IdxW-1:0]           lookup_index_o,
  output logic [2:0]                         path_code_o,
  output logic [1:0]                         error_code_o
);

  localparam logic [tao_pkg::IdxW-1:0] Entries = tao_pkg::IdxW'(TABLE_ENTRIES);

  logic [tao_pkg::ValW-1:0] mem [TABLE_ENTRIES];

  tao_pkg::meta_t             meta_d, meta1_q;
  logic [tao_pkg::IdxW-1:0]   idx_d, idx1_q;
  logic                       look_d, look1_q;
  logic                       wr_en;
  logic [tao_pkg::ValW-1:0]   rd_q;

  always_comb begin
    meta_d = meta_i;
    idx_d  = '0;
    look_d = 1'b0;
    if (meta_i.valid && !meta_i.load && meta_i.path != tao_pkg::PATH_ZERO &&
        meta_i.err == tao_pkg::ERR_NONE) begin
      if (neg_i) begin
        // negative quotient unless it truncated to zero
        if (big_i || quo_i != '0) begin
          meta_d.err = tao_pkg::ERR_RANGE;
        end else begin
          look_d = 1'b1;
        end
      end else if (big_i || {1'b0, quo_i} >= {1'b0, Entries}) begin
        meta_d.err = tao_pkg::ERR_RANGE;
      end else begin
        look_d = 1'b1;
        idx_d  = quo_i;
      end
    end
    wr_en = meta_i.valid && meta_i.load && (meta_i.entry_idx < Entries);
  end

  // Loads and reads meet the memory at the same stage, so order holds.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[meta_i.entry_idx] <= meta_i.entry_val;
    end
    rd_q <= mem[look_d ? idx_d : '0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
    end else begin
      meta1_q <= meta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q  <= idx_d;
    look1_q <= look_d;
  end

  logic [tao_pkg::AngW-1:0] ang_d;

  always_comb begin
    ang_d = {rd_q[tao_pkg::ValW-1], rd_q};
    if (!meta1_q.z_less) ang_d = tao_pkg::QuarterTurn - ang_d;
    if (meta1_q.neg_x)   ang_d = tao_pkg::HalfTurn - ang_d;
    if (meta1_q.neg_z)   ang_d = '0 - ang_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= meta1_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_o        <= look1_q ? ang_d : '0;
    lookup_index_o <= look1_q ? idx1_q : '0;
    path_code_o    <= meta1_q.path;
    error_code_o   <= meta1_q.err;
  end

endmodule

`default_nettype wire

/* hdl/table_atan2_octant_unit.sv */
// ----------------------------------------------------------------------------
// table_atan2_octant_unit
// Two-argument arctangent by ratio lookup in a 1025-word angle table.
// ----------------------------------------------------------------------------
// Every transaction (table load or angle query) gives exactly one result,
// strobed on done_o for one cycle at the end of the pipeline. busy_o
// stays low: a transaction may start in every cycle, and the receiver cannot
// stall the results. A transaction passes through the input register, the
// 11-stage divider (one quotient bit per stage) behind its own input register,
// the table memory read and the output register. A table entry must be loaded
// before a query can use it.
`default_nettype none

module table_atan2_octant_unit #(
  parameter int TABLE_ENTRIES = tao_pkg::TableEntries
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  output logic                             busy_o,
  input  wire                              action_i,
  input  wire  [10:0]                      entry_index_i,
  input  wire  signed [15:0]               entry_value_i,
  input  wire  signed [31:0]               z_value_i,
  input  wire  signed [31:0]               x_value_i,
  output logic                             done_o,
  output logic signed [16:0]               angle_o,
  output logic [10:0]                      lookup_index_o,
  output logic [2:0]                       path_code_o,
  output logic [1:0]                       error_code_o
);

  assign busy_o = 1'b0;

  logic [31:0]    zu, xu, mag_lo, mag_hi, num_d, den_d;
  logic           neg_z, neg_x, z_less, reduced;
  tao_pkg::meta_t meta_d, meta_a_q;
  logic [31:0]    num_a_q, den_a_q;

  always_comb begin
    neg_z   = z_value_i[31];
    neg_x   = x_value_i[31];
    zu      = neg_z ? (~z_value_i + 32'd1) : z_value_i;
    xu      = neg_x ? (~x_value_i + 32'd1) : x_value_i;
    z_less  = ($signed(zu) < $signed(xu));
    mag_lo  = z_less ? zu : xu;
    mag_hi  = z_less ? xu : zu;
    reduced = |(mag_lo & tao_pkg::ReduceMask);
    num_d   = reduced ? mag_lo : (mag_lo << tao_pkg::RatioShift);
    den_d   = reduced ? 32'($signed(mag_hi) >>> tao_pkg::RatioShift) : mag_hi;

    meta_d           = '0;
    meta_d.valid     = start_i;
    meta_d.load      = !action_i;
    meta_d.neg_z     = neg_z;
    meta_d.neg_x     = neg_x;
    meta_d.z_less    = z_less;
    meta_d.entry_idx = entry_index_i;
    meta_d.entry_val = entry_value_i;
    meta_d.err       = tao_pkg::ERR_NONE;
    if (!action_i) begin
      meta_d.path = tao_pkg::PATH_LOAD;
    end else if (zu == '0 && xu == '0) begin
      meta_d.path = tao_pkg::PATH_ZERO;
    end else begin
      if (z_less) begin
        meta_d.path = reduced ? tao_pkg::PATH_ZRED : tao_pkg::PATH_ZSHF;
      end else begin
        meta_d.path = reduced ? tao_pkg::PATH_XRED : tao_pkg::PATH_XSHF;
      end
      if (den_d == '0) begin
        meta_d.err = tao_pkg::ERR_DIV0;
      end else if (num_d == 32'h8000_0000 && den_d == 32'hffff_ffff) begin
        meta_d.err = tao_pkg::ERR_OVF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_a_q <= '0;
    end else begin
      meta_a_q <= meta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_a_q <= num_d;
    den_a_q <= den_d;
  end

  tao_pkg::meta_t             meta_v;
  logic [tao_pkg::DivSteps-1:0] quo_v;
  logic                       big_v, neg_v;

  tao_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .meta_i (meta_a_q),
    .num_i  (num_a_q),
    .den_i  (den_a_q),
    .meta_o (meta_v),
    .quo_o  (quo_v),
    .big_o  (big_v),
    .neg_o  (neg_v)
  );

  tao_tab #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_tab (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .meta_i         (meta_v),
    .quo_i          (quo_v),
    .big_i          (big_v),
    .neg_i          (neg_v),
    .done_o         (done_o),
    .angle_o        (angle_o),
    .lookup_index_o (lookup_index_o),
    .path_code_o    (path_code_o),
    .error_code_o   (error_code_o)
  );

  a_done_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(tao_pkg::PipeLat) done_o)
    else $error("transaction result missing");

  a_err_zero_angle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_code_o != tao_pkg::ERR_NONE) |->
      (angle_o == '0 && lookup_index_o == '0))
    else $error("faulted transaction carries angle");

  a_load_ack_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && path_code_o == tao_pkg::PATH_LOAD) |->
      (error_code_o == tao_pkg::ERR_NONE && angle_o == '0))
    else $error("load ack not clean");

endmodule

`default_nettype wire
